// ===== src/gsms_pkg.sv =====
// ----------------------------------------------------------------------------
// gsms_pkg
// Shared widths, register indexes, reset values and the command and status
// structs between the shift sequencer's controller and its datapath.
// ----------------------------------------------------------------------------
package gsms_pkg;

  // Default angle sensor resolution
  localparam int ANGLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int DUTY_W     = 16;
  localparam int TICK_W     = 16;
  localparam int STALL_W    = 12;
  localparam int GEAR_W     = 12;
  localparam int STEPS_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Ramp divider: one quotient bit per cycle
  localparam int DIV_STEPS = DUTY_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GEAR  = 3'd5;

  // Configuration reset values
  localparam logic [DUTY_W-1:0]  RST_RAMP_START  = 16'd144;
  localparam logic [DUTY_W-1:0]  RST_RAMP_END    = 16'd400;
  localparam logic [TICK_W-1:0]  RST_RAMP_TICKS  = 16'd175;
  localparam logic [TICK_W-1:0]  RST_STALL_TICKS = 16'd100;
  localparam logic [STALL_W-1:0] RST_STALL_THR   = 12'd20;
  localparam logic [GEAR_W-1:0]  RST_ANGLE_GEAR  = 12'd432;

  // Item kinds
  localparam logic KIND_SHIFT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic shift_upd;  // start a new move
    logic tick_upd;   // count a tick, set up the ramp
    logic mul;        // form tick * duty span
    logic div_step;   // one quotient bit
    logic apply;      // duty, stall and end of travel
    logic out_load;   // load the result register
  } gsms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_shift;
    logic moving;
    logic need_ramp;
    logic div_last;
  } gsms_sts_t;

endpackage

// ===== src/gsms_req_if.sv =====
// ----------------------------------------------------------------------------
// gsms_req_if / gsms_rsp_if
// Valid/ready channels carrying shift and tick items in, and results out.
// ----------------------------------------------------------------------------
interface gsms_req_if #(
  parameter int ANGLE_BITS = gsms_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic                         direction;
  logic [gsms_pkg::STEPS_W-1:0] gear_steps;
  logic [ANGLE_BITS-1:0]        angle;

  modport source (output valid, kind, direction, gear_steps, angle, input ready);
  modport sink   (input valid, kind, direction, gear_steps, angle, output ready);
endinterface

interface gsms_rsp_if #(
  parameter int ANGLE_BITS = gsms_pkg::ANGLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [gsms_pkg::DUTY_W-1:0] duty_up;
  logic [gsms_pkg::DUTY_W-1:0] duty_down;
  logic                        driver_awake;
  logic                        shift_done;
  logic                        stalled;
  logic [ANGLE_BITS-1:0]       travel_delta;
  logic [gsms_pkg::TICK_W-1:0] end_travel_time;
  logic [ANGLE_BITS-1:0]       end_travel_delta;

  modport source (output valid, duty_up, duty_down, driver_awake, shift_done, stalled,
                  travel_delta, end_travel_time, end_travel_delta, input ready);
  modport sink   (input valid, duty_up, duty_down, driver_awake, shift_done, stalled,
                  travel_delta, end_travel_time, end_travel_delta, output ready);
endinterface

// ===== src/gsms_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsms_ctrl
// Sequencing state machine: accepts an item, steps the datapath through the
// shift update, or the tick update, ramp multiply, divide and apply, then hands the result out.
// ----------------------------------------------------------------------------
module gsms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output gsms_pkg::gsms_cmd_t cmd,
  input  gsms_pkg::gsms_sts_t sts
);
  import gsms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_shift) begin
          cmd.shift_upd = 1'b1;
          state_next    = S_FIN;
        end else if (!sts.moving) begin
          state_next = S_FIN;
        end else begin
          cmd.tick_upd = 1'b1;
          state_next   = sts.need_ramp ? S_MUL : S_APPLY;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait for the result register to be free
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/gsms_dp.sv =====
// ----------------------------------------------------------------------------
// gsms_dp
// Configuration registers, move state, ramp multiply and a shift-subtract
// divider, stall and end-of-travel checks, and the result register.
// ----------------------------------------------------------------------------
module gsms_dp #(
  parameter int ANGLE_BITS = gsms_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [gsms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsms_pkg::CFG_DATA_W-1:0] cfg_data,
  // item payload
  input  logic                          kind,
  input  logic                          direction,
  input  logic [gsms_pkg::STEPS_W-1:0]  gear_steps,
  input  logic [ANGLE_BITS-1:0]         angle,
  // result payload
  output logic [gsms_pkg::DUTY_W-1:0]   duty_up,
  output logic [gsms_pkg::DUTY_W-1:0]   duty_down,
  output logic                          driver_awake,
  output logic                          shift_done,
  output logic                          stalled,
  output logic [ANGLE_BITS-1:0]         travel_delta,
  output logic [gsms_pkg::TICK_W-1:0]   end_travel_time,
  output logic [ANGLE_BITS-1:0]         end_travel_delta,
  // control
  input  gsms_pkg::gsms_cmd_t           cmd,
  output gsms_pkg::gsms_sts_t           sts
);
  import gsms_pkg::*;

  localparam int CMP_W = (ANGLE_BITS > STALL_W) ? ANGLE_BITS : STALL_W;
  localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // configuration registers
  logic [DUTY_W-1:0]  ramp_start_duty;
  logic [DUTY_W-1:0]  ramp_end_duty;
  logic [TICK_W-1:0]  ramp_ticks;
  logic [TICK_W-1:0]  stall_ticks;
  logic [STALL_W-1:0] stall_threshold;
  logic [GEAR_W-1:0]  angle_per_gear;

  // captured item
  logic                  item_kind;
  logic                  item_dir;
  logic [STEPS_W-1:0]    item_steps;
  logic [ANGLE_BITS-1:0] item_angle;

  // move state
  logic [ANGLE_BITS-1:0] start_angle;
  logic [TICK_W-1:0]     travel_limit;
  logic [TICK_W-1:0]     tick_count;
  logic                  moving;
  logic                  move_down;
  logic                  done_flag;
  logic                  stall_flag;
  logic [DUTY_W-1:0]     duty_now;
  logic [TICK_W-1:0]     end_time;
  logic [ANGLE_BITS-1:0] end_delta;

  // ramp working registers
  logic                  ramp_phase;
  logic                  ramp_up;
  logic [DUTY_W-1:0]     ramp_span;
  logic [TICK_W-1:0]     div_rem;
  logic [DUTY_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0]  div_cnt;

  // combinational helpers
  logic [TICK_W-1:0]     tick_inc;
  logic [ANGLE_BITS-1:0] wrap_m;
  logic [ANGLE_BITS-1:0] delta;
  logic [ANGLE_BITS-1:0] raw_move;
  logic [2*TICK_W-1:0]   product;
  logic [TICK_W:0]       div_trial;
  logic                  div_fit;
  logic [DUTY_W-1:0]     duty_ramp;
  logic                  stall_hit;
  logic                  end_hit;

  // saturating tick count
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + TICK_W'(1);

  // wrapped absolute delta from the start angle
  assign wrap_m = item_angle - start_angle;
  assign delta  = (wrap_m <= ANGLE_HALF) ? wrap_m : (~wrap_m + ANGLE_BITS'(1));

  // plain raw movement for the stall check
  assign raw_move = (start_angle >= item_angle) ? (start_angle - item_angle)
                                                : (item_angle - start_angle);

  assign product   = tick_count * ramp_span;
  assign div_trial = {div_rem, div_quo[DUTY_W-1]};
  assign div_fit   = (div_trial >= {1'b0, ramp_ticks});
  assign duty_ramp = ramp_up ? (ramp_start_duty + div_quo) : (ramp_start_duty - div_quo);

  assign stall_hit = ramp_phase && (tick_count > stall_ticks)
                     && (CMP_W'(raw_move) < CMP_W'(stall_threshold));
  assign end_hit   = (TICK_W'(delta) >= travel_limit);

  assign sts.is_shift  = (item_kind == KIND_SHIFT);
  assign sts.moving    = moving;
  assign sts.need_ramp = (tick_inc <= ramp_ticks);
  assign sts.div_last  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_start_duty <= RST_RAMP_START;
      ramp_end_duty   <= RST_RAMP_END;
      ramp_ticks      <= RST_RAMP_TICKS;
      stall_ticks     <= RST_STALL_TICKS;
      stall_threshold <= RST_STALL_THR;
      angle_per_gear  <= RST_ANGLE_GEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAMP_START:  ramp_start_duty <= cfg_data[DUTY_W-1:0];
        REG_RAMP_END:    ramp_end_duty   <= cfg_data[DUTY_W-1:0];
        REG_RAMP_TICKS:  ramp_ticks      <= cfg_data[TICK_W-1:0];
        REG_STALL_TICKS: stall_ticks     <= cfg_data[TICK_W-1:0];
        REG_STALL_THR:   stall_threshold <= cfg_data[STALL_W-1:0];
        REG_ANGLE_GEAR:  angle_per_gear  <= cfg_data[GEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, ramp multiply and divide
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind  <= kind;
      item_dir   <= direction;
      item_steps <= gear_steps;
      item_angle <= angle;
    end
    if (cmd.tick_upd) begin
      ramp_up   <= (ramp_end_duty >= ramp_start_duty);
      ramp_span <= (ramp_end_duty >= ramp_start_duty) ? (ramp_end_duty - ramp_start_duty)
                                                      : (ramp_start_duty - ramp_end_duty);
    end
    // high half is below ramp_ticks, so the quotient fits in DUTY_W bits
    if (cmd.mul) begin
      div_rem <= product[2*TICK_W-1:TICK_W];
      div_quo <= product[DUTY_W-1:0];
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= div_fit ? TICK_W'(div_trial - {1'b0, ramp_ticks}) : div_trial[TICK_W-1:0];
      div_quo <= {div_quo[DUTY_W-2:0], div_fit};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle  <= '0;
      travel_limit <= '0;
      tick_count   <= '0;
      moving       <= 1'b0;
      move_down    <= 1'b0;
      done_flag    <= 1'b0;
      stall_flag   <= 1'b0;
      duty_now     <= '0;
      end_time     <= '0;
      end_delta    <= '0;
      ramp_phase   <= 1'b0;
    end else if (cmd.shift_upd) begin
      done_flag    <= 1'b0;
      stall_flag   <= 1'b0;
      travel_limit <= TICK_W'(angle_per_gear * item_steps);
      start_angle  <= item_angle;
      move_down    <= item_dir;
      tick_count   <= '0;
      duty_now     <= '0;
      moving       <= 1'b1;
    end else if (cmd.tick_upd) begin
      tick_count <= tick_inc;
      ramp_phase <= sts.need_ramp;
    end else if (cmd.apply) begin
      if (end_hit) begin
        if (!done_flag) begin
          end_delta <= delta;
          end_time  <= tick_count;
        end
        done_flag <= 1'b1;
        moving    <= 1'b0;
        duty_now  <= '0;
      end else if (stall_hit) begin
        moving   <= 1'b0;
        duty_now <= '0;
      end else begin
        duty_now <= ramp_phase ? duty_ramp : ramp_end_duty;
      end
      if (stall_hit) begin
        stall_flag <= 1'b1;
        moving     <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      duty_up          <= (moving && !move_down) ? duty_now : '0;
      duty_down        <= (moving && move_down) ? duty_now : '0;
      driver_awake     <= moving;
      shift_done       <= done_flag;
      stalled          <= stall_flag;
      travel_delta     <= delta;
      end_travel_time  <= end_time;
      end_travel_delta <= end_delta;
    end
  end

endmodule

// ===== src/gear_shift_motor_sequencer.sv =====
// ----------------------------------------------------------------------------
// gear_shift_motor_sequencer
// Runs one shift move over two PWM duty channels, ramping the duty and
// stopping on stall or at end of travel as measured by an angle sensor.
// ----------------------------------------------------------------------------
// Sequence: a shift item or an idle tick passes from accept through EXEC to FIN;
//   a tick past the ramp adds APPLY, and a tick inside the ramp adds one
//   multiply and a shift-subtract divider for the ramp step before APPLY.
// Output: FIN waits for the result register to be free; the next item is
//   taken while the previous result still waits for output.
// Reset: synchronous; clears the move state and loads the default settings.
// ----------------------------------------------------------------------------
module gear_shift_motor_sequencer #(
  parameter int ANGLE_BITS = gsms_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gsms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsms_pkg::CFG_DATA_W-1:0] cfg_data,
  gsms_req_if.sink                        request,
  gsms_rsp_if.source                      result
);
  import gsms_pkg::*;

  gsms_cmd_t cmd;
  gsms_sts_t sts;

  // sequencing
  gsms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and state
  gsms_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .kind             (request.kind),
    .direction        (request.direction),
    .gear_steps       (request.gear_steps),
    .angle            (request.angle),
    .duty_up          (result.duty_up),
    .duty_down        (result.duty_down),
    .driver_awake     (result.driver_awake),
    .shift_done       (result.shift_done),
    .stalled          (result.stalled),
    .travel_delta     (result.travel_delta),
    .end_travel_time  (result.end_travel_time),
    .end_travel_delta (result.end_travel_delta),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
